// File: sv/aofb_pkg.sv
// Package: types, constants and AES helper functions for the OFB byte cipher.
package aofb_pkg;

  localparam int unsigned KeyBits = 128;
  localparam int unsigned KeyNk = (KeyBits >= 256) ? 8 : ((KeyBits >= 192) ? 6 : 4);
  localparam int unsigned KeyNr = KeyNk + 6;
  localparam int unsigned SchedWords = 4 * (KeyNr + 1);
  localparam int unsigned WordIdxW = $clog2(SchedWords);
  localparam int unsigned RoundIdxW = $clog2(KeyNr + 1);

  localparam logic [1:0] CmdRead   = 2'd0;
  localparam logic [1:0] CmdWrite  = 2'd1;
  localparam logic [1:0] CmdLoad   = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic [2:0] RegKey0    = 3'd0;
  localparam logic [2:0] RegKey1    = 3'd1;
  localparam logic [2:0] RegKey2    = 3'd2;
  localparam logic [2:0] RegKey3    = 3'd3;
  localparam logic [2:0] RegRdIvHi  = 3'd4;
  localparam logic [2:0] RegRdIvLo  = 3'd5;
  localparam logic [2:0] RegWrIvHi  = 3'd6;
  localparam logic [2:0] RegWrIvLo  = 3'd7;

  typedef enum logic [2:0] {
    StIdle,
    StExpand,
    StEncWr,
    StEncRd,
    StEncByte,
    StOut
  } state_e;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // One AES round (round key not added) on a block with byte 0 in bits 127:120.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] sb [16];
    logic [7:0] t [16];
    logic [7:0] all;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        sb[4*c+k] = Sbox[s[127-8*(4*((c+k)%4)+k) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      all = sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3];
      for (int k = 0; k < 4; k++) begin
        t[4*c+k] = last ? sb[4*c+k]
                        : sb[4*c+k] ^ all ^ xtime(sb[4*c+k] ^ sb[4*c+((k+1)%4)]);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = t[i];
    end
    aes_round = r;
  endfunction

endpackage

// File: sv/aes_ofb_duplex_byte_cipher.sv
// Top level: byte-wise AES-OFB cipher with separate read and write keystreams.
// Byte transaction: result valid the cycle after acceptance unless a refill is needed;
//   a refill runs one AES round per cycle on a shared round unit before the result.
// Load transaction: key schedule one word per cycle (SchedWords words, 44 for AES-128),
//   then the write and read IVs are encrypted in turn; no result. One transaction at a time.
// Reset (async, active low) clears keystreams, positions, config and control state.
module aes_ofb_duplex_byte_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_in
  input  logic [1:0]  s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // byte_out
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned SchedIdxW = aofb_pkg::WordIdxW;

  aofb_pkg::state_e state_q, state_d;

  logic [63:0]  key_q [4];
  logic [127:0] rd_iv_q, wr_iv_q;
  logic [127:0] rd_ks_q, rd_ks_d, wr_ks_q, wr_ks_d;
  logic [4:0]   rd_pos_q, rd_pos_d, wr_pos_q, wr_pos_d;
  logic         dir_q, dir_d;             // 1: write direction
  logic [7:0]   byte_q, byte_d;
  logic [7:0]   out_q, out_d;

  // block under encryption and round counter
  logic [127:0] blk_q, blk_d;
  logic [aofb_pkg::RoundIdxW-1:0] rnd_q, rnd_d;

  // round key memory: one 128-bit round key per entry
  logic [127:0] sched_mem [aofb_pkg::KeyNr+1];
  logic [SchedIdxW-1:0] widx_q, widx_d;
  logic [31:0] wnew;
  logic [31:0] wcur;                      // schedule word of index widx_q
  logic        wwe;
  // last three schedule words, assembled into a round key with wcur
  logic [95:0] acc_q, acc_d;
  // sliding window of the last KeyNk schedule words, newest in slot KeyNk-1
  logic [31:0] win_q [aofb_pkg::KeyNk];
  logic [31:0] win_d [aofb_pkg::KeyNk];
  logic [7:0]  rcon_q, rcon_d;

  // round key read from memory, registered
  logic [127:0] rk_q;
  logic [aofb_pkg::RoundIdxW-1:0] rk_rd;

  logic [255:0] key_flat;
  assign key_flat = {key_q[0], key_q[1], key_q[2], key_q[3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      rd_iv_q <= '0;
      wr_iv_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aofb_pkg::RegKey0:   key_q[0] <= cfg_data_i;
        aofb_pkg::RegKey1:   key_q[1] <= cfg_data_i;
        aofb_pkg::RegKey2:   key_q[2] <= cfg_data_i;
        aofb_pkg::RegKey3:   key_q[3] <= cfg_data_i;
        aofb_pkg::RegRdIvHi: rd_iv_q[127:64] <= cfg_data_i;
        aofb_pkg::RegRdIvLo: rd_iv_q[63:0] <= cfg_data_i;
        aofb_pkg::RegWrIvHi: wr_iv_q[127:64] <= cfg_data_i;
        aofb_pkg::RegWrIvLo: wr_iv_q[63:0] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // key schedule step: one word per cycle, the key words first
  logic [31:0] tw;
  logic [SchedIdxW-1:0] wmod;
  always_comb begin
    tw   = win_q[aofb_pkg::KeyNk-1];
    wmod = SchedIdxW'(widx_q % SchedIdxW'(aofb_pkg::KeyNk));
    wnew = '0;
    if (wmod == '0) begin
      tw = {aofb_pkg::Sbox[tw[23:16]] ^ rcon_q, aofb_pkg::Sbox[tw[15:8]],
            aofb_pkg::Sbox[tw[7:0]], aofb_pkg::Sbox[tw[31:24]]};
    end else if (aofb_pkg::KeyNk > 6 && wmod == SchedIdxW'(4)) begin
      tw = {aofb_pkg::Sbox[tw[31:24]], aofb_pkg::Sbox[tw[23:16]],
            aofb_pkg::Sbox[tw[15:8]], aofb_pkg::Sbox[tw[7:0]]};
    end
    wnew = win_q[0] ^ tw;
    wcur = (widx_q < SchedIdxW'(aofb_pkg::KeyNk)) ? key_flat[255-32*widx_q[2:0] -: 32]
                                                   : wnew;
  end

  // memory: a round key is written once its fourth word is known, one read a cycle
  always_ff @(posedge clk_i) begin
    if (wwe && widx_q[1:0] == 2'd3) sched_mem[widx_q[SchedIdxW-1:2]] <= {acc_q, wcur};
    rk_q <= sched_mem[rk_rd];
  end

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  logic last_rnd;
  assign last_rnd = (rnd_q == aofb_pkg::RoundIdxW'(aofb_pkg::KeyNr));
  // round key needed next cycle is round rnd_d
  assign rk_rd = rnd_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      aofb_pkg::StIdle: begin
        if (in_acc) begin
          if (s_axis_tuser == aofb_pkg::CmdLoad) state_d = aofb_pkg::StExpand;
          else if (s_axis_tuser == aofb_pkg::CmdRead) begin
            state_d = (rd_pos_q[4]) ? aofb_pkg::StEncByte : aofb_pkg::StOut;
          end else if (s_axis_tuser == aofb_pkg::CmdWrite) begin
            state_d = (wr_pos_q[4]) ? aofb_pkg::StEncByte : aofb_pkg::StOut;
          end
        end
      end
      aofb_pkg::StExpand:
        if (widx_q == SchedIdxW'(aofb_pkg::SchedWords - 1)) state_d = aofb_pkg::StEncWr;
      aofb_pkg::StEncWr:   if (last_rnd) state_d = aofb_pkg::StEncRd;
      aofb_pkg::StEncRd:   if (last_rnd) state_d = aofb_pkg::StIdle;
      aofb_pkg::StEncByte: if (last_rnd) state_d = aofb_pkg::StOut;
      aofb_pkg::StOut:     if (m_axis_tready) state_d = aofb_pkg::StIdle;
      default: state_d = aofb_pkg::StIdle;
    endcase
  end

  // datapath / outputs
  always_comb begin
    rd_ks_d = rd_ks_q;
    wr_ks_d = wr_ks_q;
    rd_pos_d = rd_pos_q;
    wr_pos_d = wr_pos_q;
    dir_d = dir_q;
    byte_d = byte_q;
    out_d = out_q;
    blk_d = blk_q;
    rnd_d = rnd_q;
    widx_d = widx_q;
    win_d = win_q;
    acc_d = acc_q;
    rcon_d = rcon_q;
    wwe = 1'b0;
    case (state_q)
      aofb_pkg::StIdle: begin
        rnd_d = '0;
        if (in_acc) begin
          byte_d = s_axis_tdata;
          dir_d  = (s_axis_tuser == aofb_pkg::CmdWrite);
          if (s_axis_tuser == aofb_pkg::CmdLoad) begin
            widx_d = '0;
            rcon_d = 8'h01;
            for (int i = 0; i < aofb_pkg::KeyNk; i++) begin
              win_d[i] = key_flat[255-32*i -: 32];
            end
            rd_pos_d = '0;
            wr_pos_d = '0;
          end else begin
            blk_d = (s_axis_tuser == aofb_pkg::CmdWrite) ? wr_ks_q : rd_ks_q;
          end
        end
      end
      aofb_pkg::StExpand: begin
        wwe = 1'b1;
        acc_d = {acc_q[63:0], wcur};
        // the window already holds the key words; it moves on derived words only
        if (widx_q >= SchedIdxW'(aofb_pkg::KeyNk)) begin
          for (int i = 0; i < aofb_pkg::KeyNk - 1; i++) win_d[i] = win_q[i+1];
          win_d[aofb_pkg::KeyNk-1] = wnew;
          if (wmod == '0) rcon_d = aofb_pkg::xtime(rcon_q);
        end
        widx_d = widx_q + SchedIdxW'(1);
        blk_d = wr_iv_q;
        rnd_d = '0;
      end
      aofb_pkg::StEncWr, aofb_pkg::StEncRd, aofb_pkg::StEncByte: begin
        // round 0 adds the key only; later rounds do the round (no MixColumns in the last) then add
        if (rnd_q == '0) blk_d = blk_q ^ rk_q;
        else blk_d = aofb_pkg::aes_round(blk_q, last_rnd) ^ rk_q;
        rnd_d = last_rnd ? '0 : rnd_q + aofb_pkg::RoundIdxW'(1);
        if (last_rnd) begin
          if (state_q == aofb_pkg::StEncWr) begin
            wr_ks_d = blk_d;
            blk_d = rd_iv_q;
          end else if (state_q == aofb_pkg::StEncRd) begin
            rd_ks_d = blk_d;
          end else begin
            if (dir_q) begin
              wr_ks_d = blk_d;
              wr_pos_d = '0;
            end else begin
              rd_ks_d = blk_d;
              rd_pos_d = '0;
            end
          end
        end
      end
      aofb_pkg::StOut: ;
      default: ;
    endcase
    // byte result computed on entry to StOut
    if (state_d == aofb_pkg::StOut && state_q != aofb_pkg::StOut) begin
      if (state_q == aofb_pkg::StEncByte) begin
        out_d = byte_d ^ blk_d[127 -: 8];
        if (dir_q) wr_pos_d = 5'd1;
        else rd_pos_d = 5'd1;
      end else begin
        if (s_axis_tuser == aofb_pkg::CmdWrite) begin
          out_d = s_axis_tdata ^ wr_ks_q[127 - 8*wr_pos_q[3:0] -: 8];
          wr_pos_d = wr_pos_q + 5'd1;
        end else begin
          out_d = s_axis_tdata ^ rd_ks_q[127 - 8*rd_pos_q[3:0] -: 8];
          rd_pos_d = rd_pos_q + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= aofb_pkg::StIdle;
      rd_ks_q  <= '0;
      wr_ks_q  <= '0;
      rd_pos_q <= '0;
      wr_pos_q <= '0;
      rnd_q    <= '0;
      widx_q   <= '0;
    end else begin
      state_q  <= state_d;
      rd_ks_q  <= rd_ks_d;
      wr_ks_q  <= wr_ks_d;
      rd_pos_q <= rd_pos_d;
      wr_pos_q <= wr_pos_d;
      rnd_q    <= rnd_d;
      widx_q   <= widx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q  <= dir_d;
    byte_q <= byte_d;
    out_q  <= out_d;
    blk_q  <= blk_d;
    win_q  <= win_d;
    acc_q  <= acc_d;
    rcon_q <= rcon_d;
  end

  assign s_axis_tready = (state_q == aofb_pkg::StIdle);
  assign m_axis_tvalid = (state_q == aofb_pkg::StOut);
  assign m_axis_tdata  = out_q;

endmodule

// File: verif/tb_aes_ofb_duplex_byte_cipher.sv
// Testbench for the byte-wise AES-OFB duplex cipher: predicted keystream checks.
module tb_aes_ofb_duplex_byte_cipher;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // byte_in
  logic [1:0]  s_axis_tuser = '0;   // command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // byte_out
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  aes_ofb_duplex_byte_cipher dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: registers, key schedule, two keystreams with positions.
  logic [63:0]  cfg_shadow [8];
  logic [127:0] sched_keys [15];
  logic [127:0] rd_stream, wr_stream;
  int unsigned  rd_pos, wr_pos;
  logic [7:0]   expected_bytes [$];
  int           fail_count = 0;

  // Traffic shaping knobs.
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  bit           hold_off = 1'b0;

  // Spread configured key into the schedule, one 32-bit word at a time.
  function automatic void expand_schedule();
    logic [31:0] w [60];
    logic [31:0] t;
    logic [255:0] kb;
    logic [7:0]  rc;
    int n;
    n = 4 * (aofb_pkg::KeyNr + 1);
    kb = {cfg_shadow[0], cfg_shadow[1], cfg_shadow[2], cfg_shadow[3]};
    rc = 8'h01;
    for (int i = 0; i < n; i++) begin
      if (i < aofb_pkg::KeyNk) begin
        w[i] = kb[255-32*i -: 32];
      end else begin
        t = w[i-1];
        if (i % aofb_pkg::KeyNk == 0) begin
          t = {aofb_pkg::Sbox[t[23:16]] ^ rc, aofb_pkg::Sbox[t[15:8]],
               aofb_pkg::Sbox[t[7:0]], aofb_pkg::Sbox[t[31:24]]};
          rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
        end else if (aofb_pkg::KeyNk > 6 && i % aofb_pkg::KeyNk == 4) begin
          t = {aofb_pkg::Sbox[t[31:24]], aofb_pkg::Sbox[t[23:16]],
               aofb_pkg::Sbox[t[15:8]], aofb_pkg::Sbox[t[7:0]]};
        end
        w[i] = w[i-aofb_pkg::KeyNk] ^ t;
      end
    end
    for (int r = 0; r <= aofb_pkg::KeyNr; r++) begin
      sched_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    end
  endfunction

  function automatic logic [7:0] mul2(input logic [7:0] a);
    mul2 = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Full block encryption; byte 0 lives in bits 127:120.
  function automatic logic [127:0] encrypt_block(input logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] all;
    logic [127:0] st;
    st = blk ^ sched_keys[0];
    for (int r = 1; r <= aofb_pkg::KeyNr; r++) begin
      for (int i = 0; i < 16; i++) s[i] = st[127-8*i -: 8];
      for (int c = 0; c < 4; c++)
        for (int k = 0; k < 4; k++)
          t[4*c+k] = aofb_pkg::Sbox[s[4*((c+k)&3)+k]];
      if (r != aofb_pkg::KeyNr) begin
        for (int c = 0; c < 4; c++) begin
          all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
          for (int k = 0; k < 4; k++) s[k] = t[4*c+k];
          for (int k = 0; k < 4; k++)
            t[4*c+k] = s[k] ^ all ^ mul2(s[k] ^ s[(k+1)%4]);
        end
      end
      for (int i = 0; i < 16; i++) st[127-8*i -: 8] = t[i];
      st = st ^ sched_keys[r];
    end
    encrypt_block = st;
  endfunction

  // Apply one accepted transaction to the predictor.
  function automatic void predict_transaction(input logic [1:0] cmd, input logic [7:0] b);
    if (cmd == aofb_pkg::CmdLoad) begin
      expand_schedule();
      rd_stream = encrypt_block({cfg_shadow[aofb_pkg::RegRdIvHi],
                                 cfg_shadow[aofb_pkg::RegRdIvLo]});
      wr_stream = encrypt_block({cfg_shadow[aofb_pkg::RegWrIvHi],
                                 cfg_shadow[aofb_pkg::RegWrIvLo]});
      rd_pos = 0;
      wr_pos = 0;
    end else if (cmd == aofb_pkg::CmdRead) begin
      if (rd_pos >= 16) begin
        rd_stream = encrypt_block(rd_stream);
        rd_pos = 0;
      end
      expected_bytes.push_back(b ^ rd_stream[127-8*rd_pos -: 8]);
      rd_pos++;
    end else if (cmd == aofb_pkg::CmdWrite) begin
      if (wr_pos >= 16) begin
        wr_stream = encrypt_block(wr_stream);
        wr_pos = 0;
      end
      expected_bytes.push_back(b ^ wr_stream[127-8*wr_pos -: 8]);
      wr_pos++;
    end
    // unused command: no effect, no result
  endfunction

  // Send one item; waits for the handshake and leaves valid high for the next item or end_burst.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_transaction(cmd, b);
    @(negedge clk_i);
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Quiet period before register writes: wait for results and the load pipeline.
  task automatic drain();
    end_burst();
    while (expected_bytes.size() != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    cfg_shadow[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_all(input logic [63:0] k0, k1, k2, k3, ri_h, ri_l, wi_h, wi_l);
    write_reg(aofb_pkg::RegKey0, k0);
    write_reg(aofb_pkg::RegKey1, k1);
    write_reg(aofb_pkg::RegKey2, k2);
    write_reg(aofb_pkg::RegKey3, k3);
    write_reg(aofb_pkg::RegRdIvHi, ri_h);
    write_reg(aofb_pkg::RegRdIvLo, ri_l);
    write_reg(aofb_pkg::RegWrIvHi, wi_h);
    write_reg(aofb_pkg::RegWrIvLo, wi_l);
  endtask

  function automatic logic [63:0] rand64();
    rand64 = {$urandom(), $urandom()};
  endfunction

  function automatic logic [7:0] rand8();
    rand8 = 8'($urandom_range(255));
  endfunction

  // Receiver: random stall, checks each result against the oldest prediction.
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("byte_out: unexpected result %02h", m_axis_tdata);
        fail_count++;
      end else begin
        if (m_axis_tdata !== expected_bytes[0]) begin
          $error("byte_out: expected %02h actual %02h", expected_bytes[0], m_axis_tdata);
          fail_count++;
        end
        void'(expected_bytes.pop_front());
      end
    end
  end

  // Directed: reset-value bytes, extreme fields, unused command, both keystreams.
  task automatic test_directed();
    // keystream is zero before any load; stay within the first 16 bytes
    send_item(aofb_pkg::CmdRead, 8'h00);
    send_item(aofb_pkg::CmdWrite, 8'hff);
    send_item(aofb_pkg::CmdUnused, 8'hff);
    send_item(aofb_pkg::CmdRead, 8'ha5);
    drain();
    program_all('0, '0, '0, '0, '0, '0, '0, '0);
    send_item(aofb_pkg::CmdLoad, 8'hff);
    for (int i = 0; i < 17; i++) send_item(aofb_pkg::CmdRead, (i[0]) ? 8'hff : 8'h00);
    send_item(aofb_pkg::CmdUnused, 8'h5a);
    send_item(aofb_pkg::CmdWrite, 8'h00);
    drain();
    program_all('1, '1, '1, '1, '1, '1, '1, '1);
    send_item(aofb_pkg::CmdLoad, 8'h00);
    send_item(aofb_pkg::CmdWrite, 8'hff);
    send_item(aofb_pkg::CmdRead, 8'h80);
    drain();
  endtask

  // Random content and load placement under one idling profile.
  task automatic test_random_phase(input int unsigned idle, stall, n);
    int unsigned r;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    program_all(rand64(), rand64(), rand64(), rand64(),
                rand64(), rand64(), rand64(), rand64());
    send_item(aofb_pkg::CmdLoad, rand8());
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 3) send_item(aofb_pkg::CmdLoad, rand8());
      else if (r < 5) send_item(aofb_pkg::CmdUnused, rand8());
      else send_item(r[0] ? aofb_pkg::CmdWrite : aofb_pkg::CmdRead, rand8());
    end
    drain();
  endtask

  // Receiver holds off while the sender keeps offering bytes.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (200) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 40; i++) begin
        send_item(($urandom_range(1) != 0) ? aofb_pkg::CmdWrite : aofb_pkg::CmdRead,
                  rand8());
      end
    join
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    for (int i = 0; i < 8; i++) cfg_shadow[i] = '0;
    for (int i = 0; i < 15; i++) sched_keys[i] = '0;
    rd_stream = '0;
    wr_stream = '0;
    rd_pos = 0;
    wr_pos = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_phase(0, 0, 250);
    test_random_phase(73, 0, 250);
    test_random_phase(0, 73, 250);
    test_random_phase(23, 23, 250);
    test_backpressure();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: sim.f
sv/aofb_pkg.sv
sv/aes_ofb_duplex_byte_cipher.sv
verif/tb_aes_ofb_duplex_byte_cipher.sv
